>>> rtl/core/sic_pkg.sv
`default_nettype none
package sic_pkg;

  localparam int CB    = 16;           // coordinate width
  localparam int FRAC  = 16;           // fraction bits of the crossing point
  localparam int DIFW  = CB + 1;       // coordinate difference
  localparam int CW    = CB + 3;       // collinear position terms
  localparam int PW    = 2 * DIFW;     // product of two differences
  localparam int DW    = 2 * CB + 4;   // determinant and numerators
  localparam int EW    = DW + 1;       // divisor (twice the determinant)
  localparam int QB    = CB + 18;      // quotient bits
  localparam int NW    = EW + QB;      // dividend
  localparam int MW    = DIFW + DW;    // delta magnitude times numerator
  localparam int OUTW  = CB + FRAC + 1;
  localparam int CODEW = 3;

  // collinear overlap ordering
  localparam logic [CODEW-1:0] OVL_NONE           = 3'd0;
  localparam logic [CODEW-1:0] OVL_AF_IN_AT_AFTER  = 3'd1;
  localparam logic [CODEW-1:0] OVL_AF_IN_AT_BEFORE = 3'd2;
  localparam logic [CODEW-1:0] OVL_AT_IN_AF_AFTER  = 3'd3;
  localparam logic [CODEW-1:0] OVL_AT_IN_AF_BEFORE = 3'd4;
  localparam logic [CODEW-1:0] OVL_INSIDE_FWD      = 3'd5;
  localparam logic [CODEW-1:0] OVL_INSIDE_REV      = 3'd6;
  localparam logic [CODEW-1:0] OVL_COVERS          = 3'd7;

  typedef struct packed {
    logic                   hit;
    logic [CODEW-1:0]       code;
    logic signed [CB-1:0]   ax0;
    logic signed [CB-1:0]   ay0;
    logic                   negx;
    logic                   negy;
  } side_t;

endpackage
`default_nettype wire

>>> rtl/core/segment_intersect_classify.sv
`default_nettype none
// channel   ports                                 transfer
// in        start, busy, in_a_*, in_b_*           start high while busy low
// out       out_valid, out_hit, out_point_*,      out_valid high, one cycle
//           out_overlap_code
//
// one segment pair per cycle; busy is always low
// a one-bit-per-stage pipelined divider places the crossing point
// synchronous active-low reset clears the valid bits only
// results leave on a one-cycle strobe; the receiver cannot stall
module segment_intersect_classify
  import sic_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [CB-1:0]    in_a_from_x,
  input  wire logic signed [CB-1:0]    in_a_from_y,
  input  wire logic signed [CB-1:0]    in_a_to_x,
  input  wire logic signed [CB-1:0]    in_a_to_y,
  input  wire logic signed [CB-1:0]    in_b_from_x,
  input  wire logic signed [CB-1:0]    in_b_from_y,
  input  wire logic signed [CB-1:0]    in_b_to_x,
  input  wire logic signed [CB-1:0]    in_b_to_y,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic signed [OUTW-1:0]       out_point_x,
  output logic signed [OUTW-1:0]       out_point_y,
  output logic        [CODEW-1:0]      out_overlap_code
);

  assign busy = 1'b0;

  // stage 1: differences
  logic v1_r;
  logic signed [DIFW-1:0] vx1_r, vy1_r, wx1_r, wy1_r, gx1_r, gy1_r, tnx1_r, tny1_r;
  logic signed [CB-1:0] ax1_r, ay1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    vx1_r  <= DIFW'(in_a_to_x) - DIFW'(in_a_from_x);
    vy1_r  <= DIFW'(in_a_to_y) - DIFW'(in_a_from_y);
    wx1_r  <= DIFW'(in_b_from_x) - DIFW'(in_b_to_x);
    wy1_r  <= DIFW'(in_b_from_y) - DIFW'(in_b_to_y);
    gx1_r  <= DIFW'(in_b_from_x) - DIFW'(in_a_from_x);
    gy1_r  <= DIFW'(in_b_from_y) - DIFW'(in_a_from_y);
    tnx1_r <= DIFW'(in_a_to_x) - DIFW'(in_b_from_x);
    tny1_r <= DIFW'(in_a_to_y) - DIFW'(in_b_from_y);
    ax1_r  <= in_a_from_x;
    ay1_r  <= in_a_from_y;
  end

  // stage 2: cross products and position along b
  logic v2_r;
  logic signed [PW-1:0] vxwy2_r, vywx2_r, gxwy2_r, gywx2_r, vxgy2_r, vygx2_r;
  logic signed [CW-1:0] den2_r, fn2_r, tn2_r;
  logic signed [DIFW-1:0] vx2_r, vy2_r;
  logic signed [CB-1:0] ax2_r, ay2_r;
  logic bzero2_r;
  logic signed [CW-1:0] den_sel, fn_sel, tn_sel;

  always_comb begin
    if (wx1_r != '0) begin
      den_sel = -CW'(wx1_r);
      fn_sel  = -CW'(gx1_r);
      tn_sel  = CW'(tnx1_r);
    end else begin
      den_sel = -CW'(wy1_r);
      fn_sel  = -CW'(gy1_r);
      tn_sel  = CW'(tny1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    vxwy2_r  <= PW'(vx1_r) * PW'(wy1_r);
    vywx2_r  <= PW'(vy1_r) * PW'(wx1_r);
    gxwy2_r  <= PW'(gx1_r) * PW'(wy1_r);
    gywx2_r  <= PW'(gy1_r) * PW'(wx1_r);
    vxgy2_r  <= PW'(vx1_r) * PW'(gy1_r);
    vygx2_r  <= PW'(vy1_r) * PW'(gx1_r);
    den2_r   <= den_sel[CW-1] ? -den_sel : den_sel;
    fn2_r    <= den_sel[CW-1] ? -fn_sel : fn_sel;
    tn2_r    <= den_sel[CW-1] ? -tn_sel : tn_sel;
    bzero2_r <= (wx1_r == '0) && (wy1_r == '0);
    vx2_r    <= vx1_r;
    vy2_r    <= vy1_r;
    ax2_r    <= ax1_r;
    ay2_r    <= ay1_r;
  end

  // stage 3: determinant and numerators
  logic v3_r;
  logic signed [DW-1:0] d03_r, na3_r, nb3_r;
  logic signed [CW-1:0] den3_r, fn3_r, tn3_r;
  logic signed [DIFW-1:0] vx3_r, vy3_r;
  logic signed [CB-1:0] ax3_r, ay3_r;
  logic bzero3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    d03_r    <= DW'(vxwy2_r) - DW'(vywx2_r);
    na3_r    <= DW'(gxwy2_r) - DW'(gywx2_r);
    nb3_r    <= DW'(vxgy2_r) - DW'(vygx2_r);
    den3_r   <= den2_r;
    fn3_r    <= fn2_r;
    tn3_r    <= tn2_r;
    bzero3_r <= bzero2_r;
    vx3_r    <= vx2_r;
    vy3_r    <= vy2_r;
    ax3_r    <= ax2_r;
    ay3_r    <= ay2_r;
  end

  // stage 4: hit test, collinear code, magnitudes
  logic hit_c, coll_c;
  logic [CODEW-1:0] code_c;

  always_comb begin
    if (d03_r > 0) begin
      hit_c = (na3_r >= 0) && (na3_r <= d03_r) && (nb3_r > 0) && (nb3_r < d03_r);
    end else if (d03_r < 0) begin
      hit_c = (na3_r <= 0) && (na3_r >= d03_r) && (nb3_r < 0) && (nb3_r > d03_r);
    end else begin
      hit_c = 1'b0;
    end
    // na is minus the collinearity cross product
    coll_c = (d03_r == '0) && (na3_r == '0) && !bzero3_r;
    code_c = OVL_COVERS;
    if ((fn3_r > 0) && (fn3_r < den3_r)) begin
      code_c = (tn3_r < 0) ? OVL_AF_IN_AT_BEFORE :
               ((tn3_r > den3_r) ? OVL_AF_IN_AT_AFTER : OVL_INSIDE_FWD);
    end
    if ((tn3_r > 0) && (tn3_r < den3_r)) begin
      code_c = (fn3_r < 0) ? OVL_AT_IN_AF_BEFORE :
               ((fn3_r > den3_r) ? OVL_AT_IN_AF_AFTER : OVL_INSIDE_FWD);
    end
    if ((code_c == OVL_INSIDE_FWD) && (fn3_r > tn3_r)) begin
      code_c = OVL_INSIDE_REV;
    end
    if (((tn3_r <= 0) && (fn3_r <= 0)) || ((tn3_r >= den3_r) && (fn3_r >= den3_r))) begin
      code_c = OVL_NONE;
    end
    if (!coll_c) begin
      code_c = OVL_NONE;
    end
  end

  logic v4_r;
  logic [DW-1:0] dabs4_r, naabs4_r;
  logic [DIFW-1:0] magx4_r, magy4_r;
  side_t side4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    dabs4_r       <= d03_r[DW-1] ? DW'(-d03_r) : DW'(d03_r);
    naabs4_r      <= d03_r[DW-1] ? DW'(-na3_r) : DW'(na3_r);
    magx4_r       <= vx3_r[DIFW-1] ? DIFW'(-vx3_r) : DIFW'(vx3_r);
    magy4_r       <= vy3_r[DIFW-1] ? DIFW'(-vy3_r) : DIFW'(vy3_r);
    side4_r.hit   <= hit_c;
    side4_r.code  <= code_c;
    side4_r.ax0   <= ax3_r;
    side4_r.ay0   <= ay3_r;
    side4_r.negx  <= vx3_r[DIFW-1];
    side4_r.negy  <= vy3_r[DIFW-1];
  end

  // stage 5: offset numerators
  logic v5_r;
  logic [MW-1:0] px5_r, py5_r;
  logic [DW-1:0] d5_r;
  side_t side5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    px5_r   <= MW'(magx4_r) * MW'(naabs4_r);
    py5_r   <= MW'(magy4_r) * MW'(naabs4_r);
    d5_r    <= dabs4_r;
    side5_r <= side4_r;
  end

  // rounding: floor((mag*na*2^(FRAC+1) + d) / 2d)
  logic [NW-1:0] numx, numy;
  logic [EW-1:0] div_den;
  logic [QB-1:0] qx, qy;

  assign numx    = (NW'(px5_r) << (FRAC + 1)) + NW'(d5_r);
  assign numy    = (NW'(py5_r) << (FRAC + 1)) + NW'(d5_r);
  assign div_den = {d5_r, 1'b0};

  sic_div u_div_x (
    .clk    (clk),
    .in_num (numx),
    .in_den (div_den),
    .out_q  (qx)
  );

  sic_div u_div_y (
    .clk    (clk),
    .in_num (numy),
    .in_den (div_den),
    .out_q  (qy)
  );

  // side data travels alongside the divider stages
  logic  vd_r   [0:QB];
  side_t sided_r[0:QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QB; k++) begin
        vd_r[k] <= 1'b0;
      end
    end else begin
      vd_r[0] <= v5_r;
      for (int k = 1; k <= QB; k++) begin
        vd_r[k] <= vd_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    sided_r[0] <= side5_r;
    for (int k = 1; k <= QB; k++) begin
      sided_r[k] <= sided_r[k-1];
    end
  end

  // output stage
  side_t sd;
  logic [OUTW-1:0] basex, basey, sumx, sumy;

  always_comb begin
    sd    = sided_r[QB];
    basex = {sd.ax0[CB-1], sd.ax0, {FRAC{1'b0}}};
    basey = {sd.ay0[CB-1], sd.ay0, {FRAC{1'b0}}};
    sumx  = sd.negx ? basex - qx[OUTW-1:0] : basex + qx[OUTW-1:0];
    sumy  = sd.negy ? basey - qy[OUTW-1:0] : basey + qy[OUTW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vd_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    out_hit          <= sd.hit;
    out_point_x      <= sd.hit ? sumx : '0;
    out_point_y      <= sd.hit ? sumy : '0;
    out_overlap_code <= sd.hit ? OVL_NONE : sd.code;
  end

endmodule
`default_nettype wire

>>> rtl/core/sic_div.sv
`default_nettype none
module sic_div
  import sic_pkg::*;
(
  input  wire logic          clk,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [EW-1:0] in_den,
  output logic      [QB-1:0] out_q
);

  logic [EW-1:0] rem_r [0:QB];
  logic [QB-1:0] num_r [0:QB];
  logic [EW-1:0] den_r [0:QB];
  logic [QB-1:0] q_r   [0:QB];

  // top part of the dividend is below the divisor since the quotient fits QB bits
  always_ff @(posedge clk) begin
    rem_r[0] <= in_num[NW-1:QB];
    num_r[0] <= in_num[QB-1:0];
    den_r[0] <= in_den;
    q_r[0]   <= '0;
  end

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [EW:0] trial;
    logic [EW:0] diff;
    logic        ge;

    always_comb begin
      trial = {rem_r[i], num_r[i][QB-1]};
      diff  = trial - {1'b0, den_r[i]};
      ge    = (trial >= {1'b0, den_r[i]});
    end

    always_ff @(posedge clk) begin
      rem_r[i+1] <= ge ? diff[EW-1:0] : trial[EW-1:0];
      num_r[i+1] <= {num_r[i][QB-2:0], 1'b0};
      den_r[i+1] <= den_r[i];
      q_r[i+1]   <= {q_r[i][QB-2:0], ge};
    end
  end

  assign out_q = q_r[QB];

endmodule
`default_nettype wire
